// File: rtl/tsd_pkg.sv
package tsd_pkg;

  // Offset applied to the normal path step so that it stays non-negative
  localparam logic [16:0] STEP_OFFSET = 17'd64000;
  // Filter outputs are clamped to this magnitude
  localparam logic signed [15:0] TORQUE_LIMIT = 16'sd32000;
  // Idle hold count above which the idle path reports instability
  localparam logic [7:0] IDLE_COUNT_LIMIT = 8'd25;

  // Configuration register indexes
  localparam int unsigned CfgIdxW = 4;
  localparam logic [CfgIdxW-1:0] CFG_NORMAL_GAIN     = 4'd0;
  localparam logic [CfgIdxW-1:0] CFG_IDLE_GAIN       = 4'd1;
  localparam logic [CfgIdxW-1:0] CFG_ACCEL_THRESHOLD = 4'd2;
  localparam logic [CfgIdxW-1:0] CFG_DECEL_THRESHOLD = 4'd3;
  localparam logic [CfgIdxW-1:0] CFG_ACCEL_HOLD      = 4'd4;
  localparam logic [CfgIdxW-1:0] CFG_DECEL_HOLD      = 4'd5;
  localparam logic [CfgIdxW-1:0] CFG_IDLE_HOLD       = 4'd6;
  localparam logic [CfgIdxW-1:0] CFG_IDLE_THRESHOLD  = 4'd7;

  typedef struct packed {
    logic signed [15:0] torque_sample;
    logic               normal_active;
    logic               idle_active;
  } tsd_in_t;

  typedef struct packed {
    logic               not_stable;
    logic               normal_reset_pulse;
    logic               idle_reset_pulse;
    logic               accel_detected;
    logic [16:0]        normal_step;
    logic [15:0]        idle_step;
    logic signed [15:0] normal_filtered;
    logic signed [15:0] idle_filtered;
  } tsd_out_t;

endpackage

// File: rtl/tsd_filt.sv
// First-order torque filter, one update per call, gain over 256.
module tsd_filt
  import tsd_pkg::*;
(
  input  logic               started_i,
  input  logic               load_req_i,
  input  logic [8:0]         gain_i,
  input  logic signed [24:0] acc_i,
  input  logic signed [15:0] out_i,
  input  logic signed [15:0] sample_i,
  output logic signed [24:0] acc_o,
  output logic signed [15:0] out_o,
  output logic signed [15:0] prev_o
);

  function automatic logic signed [15:0] clamp18(input logic signed [17:0] v);
    logic signed [17:0] lim;
    lim = {{2{TORQUE_LIMIT[15]}}, TORQUE_LIMIT};
    if (v > lim) begin
      return TORQUE_LIMIT;
    end else if (v < -lim) begin
      return -TORQUE_LIMIT;
    end else begin
      return v[15:0];
    end
  endfunction

  logic               load;
  logic signed [24:0] samp_sc;
  logic signed [24:0] diff;
  logic signed [8:0]  gain_s;
  logic signed [33:0] prod;
  logic               trunc_fix;
  logic signed [24:0] quot;
  logic signed [24:0] acc_upd;
  logic signed [25:0] rnd;
  logic signed [15:0] out_upd;
  logic signed [15:0] samp_cl;

  // Load directly on first run, on a path reset, or at a gain of 256 or more
  assign load = !started_i || load_req_i || gain_i[8];

  // Scale the sample, take the error against the accumulator and weight it
  assign samp_sc = {sample_i[15], sample_i, 8'h00};
  assign diff    = samp_sc - acc_i;
  assign gain_s  = {1'b0, gain_i[7:0]};
  assign prod    = diff * gain_s;

  // Divide by 256 truncating towards zero
  assign trunc_fix = prod[33] && (prod[7:0] != 8'h00);
  assign quot      = prod[32:8] + {24'd0, trunc_fix};
  assign acc_upd   = acc_i + quot;

  // Round half up to the output scale, then clamp
  assign rnd     = {acc_upd[24], acc_upd} + 26'sd128;
  assign out_upd = clamp18(rnd[25:8]);
  assign samp_cl = clamp18({{2{sample_i[15]}}, sample_i});

  always_comb begin
    if (load) begin
      out_o = samp_cl;
      acc_o = {samp_cl[15], samp_cl, 8'h00};
    end else begin
      out_o = out_upd;
      acc_o = acc_upd;
    end
  end

  // Previous output; on the first run it equals the new one
  assign prev_o = started_i ? out_i : out_o;

endmodule

// File: rtl/torque_stability_detector.sv
// Channel | Direction | Handshake                  | Payload
// in      | input     | in_valid_i / in_ready_o    | in_data_i  (tsd_in_t)
// out     | output    | out_valid_o / out_ready_i  | out_data_o (tsd_out_t)
// cfg     | input     | cfg_valid_i / cfg_ready_o  | cfg_index_i, cfg_data_i
//
// One sample per cycle sustained while the result is not stalled; a sample moves
// from the input register to the result register once the result register is free or
// being read. The shared 25x8 filter multiply and the step compares sit between them.
// Reset clears the filter state, hold counters and configuration to defaults.
// With the result stalled, one more sample is held in the input register.
module torque_stability_detector
  import tsd_pkg::*;
(
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               in_valid_i,
  output logic               in_ready_o,
  input  tsd_in_t            in_data_i,
  output logic               out_valid_o,
  input  logic               out_ready_i,
  output tsd_out_t           out_data_o,
  input  logic               cfg_valid_i,
  output logic               cfg_ready_o,
  input  logic [CfgIdxW-1:0] cfg_index_i,
  input  logic [15:0]        cfg_data_i
);

  // Configuration registers
  logic [8:0]  normal_gain_q, idle_gain_q;
  logic [15:0] accel_thr_q, decel_thr_q, idle_thr_q;
  logic [7:0]  accel_hold_q, decel_hold_q, idle_hold_q;

  // Path state
  logic               last_n_q, last_i_q;
  logic               n_started_q, i_started_q;
  logic signed [24:0] n_acc_q, i_acc_q;
  logic signed [15:0] n_out_q, i_out_q;
  logic [7:0]         n_hold_q, i_hold_q;

  // Input and result registers
  logic     stg_valid_q;
  tsd_in_t  stg_q;
  logic     out_valid_q;
  tsd_out_t res_q;

  logic advance;
  logic norm, idle, run_idle;
  logic rst_n, rst_i;

  logic               f_started, f_load_req;
  logic [8:0]         f_gain;
  logic signed [24:0] f_acc_in, f_acc;
  logic signed [15:0] f_out_in, f_out, f_prev;

  logic signed [17:0] dn;
  logic [16:0]        nstep;
  logic               accel;
  logic [17:0]        accel_lim;
  logic               reload_n;
  logic [7:0]         n_hold_d;
  logic signed [16:0] di;
  logic [16:0]        di_abs;
  logic [15:0]        istep;
  logic               reload_i;
  logic [7:0]         i_hold_d;
  logic               not_stable;
  tsd_out_t           res_d;

  assign cfg_ready_o = 1'b1;
  assign advance     = stg_valid_q && (!out_valid_q || out_ready_i);
  assign in_ready_o  = !stg_valid_q || advance;
  assign out_valid_o = out_valid_q;
  assign out_data_o  = res_q;

  assign norm     = stg_q.normal_active;
  assign idle     = stg_q.idle_active;
  assign run_idle = !norm && idle;
  assign rst_n    = norm && !last_n_q;
  assign rst_i    = idle && !last_i_q;

  // Steer the shared filter to whichever path runs
  assign f_started  = norm ? n_started_q   : i_started_q;
  assign f_load_req = norm ? rst_n         : rst_i;
  assign f_gain     = norm ? normal_gain_q : idle_gain_q;
  assign f_acc_in   = norm ? n_acc_q       : i_acc_q;
  assign f_out_in   = norm ? n_out_q       : i_out_q;

  tsd_filt u_filt (
    .started_i  (f_started),
    .load_req_i (f_load_req),
    .gain_i     (f_gain),
    .acc_i      (f_acc_in),
    .out_i      (f_out_in),
    .sample_i   (stg_q.torque_sample),
    .acc_o      (f_acc),
    .out_o      (f_out),
    .prev_o     (f_prev)
  );

  // Normal path: offset step, classify and reload the hold counter
  always_comb begin
    dn = {{2{f_out[15]}}, f_out} - {{2{f_prev[15]}}, f_prev}
         + $signed({1'b0, STEP_OFFSET});
    if (!norm) begin
      nstep = 17'd0;
    end else if (rst_n) begin
      nstep = STEP_OFFSET;
    end else if (dn[17]) begin
      nstep = 17'd0;
    end else begin
      nstep = dn[16:0];
    end
    accel     = norm && (nstep >= STEP_OFFSET);
    accel_lim = {2'b00, accel_thr_q} + {1'b0, STEP_OFFSET};
    reload_n  = ({1'b0, nstep} > accel_lim) || (nstep < {1'b0, decel_thr_q}) || rst_n;
    if (reload_n) begin
      n_hold_d = accel ? accel_hold_q : decel_hold_q;
    end else if (n_hold_q != 8'd0) begin
      n_hold_d = n_hold_q - 8'd1;
    end else begin
      n_hold_d = 8'd0;
    end
  end

  // Idle path: absolute step against the threshold
  always_comb begin
    di     = {f_out[15], f_out} - {f_prev[15], f_prev};
    di_abs = di[16] ? 17'(-di) : 17'(di);
    istep  = (run_idle && !rst_i) ? di_abs[15:0] : 16'd0;
    reload_i = (istep > idle_thr_q) || rst_i;
    if (reload_i) begin
      i_hold_d = idle_hold_q;
    end else if (i_hold_q != 8'd0) begin
      i_hold_d = i_hold_q - 8'd1;
    end else begin
      i_hold_d = 8'd0;
    end
  end

  // Assemble the result
  always_comb begin
    if (norm) begin
      not_stable = (n_hold_d != 8'd0);
    end else if (idle) begin
      not_stable = (i_hold_d > IDLE_COUNT_LIMIT);
    end else begin
      not_stable = 1'b1;
    end
    res_d.not_stable         = not_stable;
    res_d.normal_reset_pulse = rst_n;
    res_d.idle_reset_pulse   = rst_i;
    res_d.accel_detected     = accel;
    res_d.normal_step        = nstep;
    res_d.idle_step          = istep;
    res_d.normal_filtered    = norm ? f_out : n_out_q;
    res_d.idle_filtered      = run_idle ? f_out : i_out_q;
  end

  // Handshake control for both registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      stg_valid_q <= 1'b0;
      out_valid_q <= 1'b0;
    end else begin
      if (in_ready_o) begin
        stg_valid_q <= in_valid_i;
      end
      if (advance) begin
        out_valid_q <= 1'b1;
      end else if (out_ready_i) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  // Payload registers: capture on transfer, hold otherwise
  always_ff @(posedge clk_i) begin
    if (in_valid_i && in_ready_o) begin
      stg_q <= in_data_i;
    end
    if (advance) begin
      res_q <= res_d;
    end
  end

  // Advance path state once per sample
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      last_n_q    <= 1'b0;
      last_i_q    <= 1'b0;
      n_started_q <= 1'b0;
      i_started_q <= 1'b0;
      n_acc_q     <= '0;
      i_acc_q     <= '0;
      n_out_q     <= '0;
      i_out_q     <= '0;
      n_hold_q    <= '0;
      i_hold_q    <= '0;
    end else if (advance) begin
      last_n_q <= norm;
      last_i_q <= idle;
      if (norm) begin
        n_started_q <= 1'b1;
        n_acc_q     <= f_acc;
        n_out_q     <= f_out;
        n_hold_q    <= n_hold_d;
      end else if (idle) begin
        i_started_q <= 1'b1;
        i_acc_q     <= f_acc;
        i_out_q     <= f_out;
        i_hold_q    <= i_hold_d;
      end
    end
  end

  // Configuration writes; unknown indexes are dropped
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      normal_gain_q <= 9'd32;
      idle_gain_q   <= 9'd32;
      accel_thr_q   <= '0;
      decel_thr_q   <= '0;
      accel_hold_q  <= '0;
      decel_hold_q  <= '0;
      idle_hold_q   <= '0;
      idle_thr_q    <= '0;
    end else if (cfg_valid_i && cfg_ready_o) begin
      case (cfg_index_i)
        CFG_NORMAL_GAIN:     normal_gain_q <= cfg_data_i[8:0];
        CFG_IDLE_GAIN:       idle_gain_q   <= cfg_data_i[8:0];
        CFG_ACCEL_THRESHOLD: accel_thr_q   <= cfg_data_i;
        CFG_DECEL_THRESHOLD: decel_thr_q   <= cfg_data_i;
        CFG_ACCEL_HOLD:      accel_hold_q  <= cfg_data_i[7:0];
        CFG_DECEL_HOLD:      decel_hold_q  <= cfg_data_i[7:0];
        CFG_IDLE_HOLD:       idle_hold_q   <= cfg_data_i[7:0];
        CFG_IDLE_THRESHOLD:  idle_thr_q    <= cfg_data_i;
        default: ;
      endcase
    end
  end

  // A normal path reset always reports the bare offset as its step
  a_nrst_step: assert property (@(posedge clk_i) disable iff (!rst_ni)
    advance && norm && rst_n |=> res_q.normal_step == STEP_OFFSET && res_q.accel_detected)
    else $error("normal reset step not at offset");

  // With neither path active the result is unstable
  a_none_unstable: assert property (@(posedge clk_i) disable iff (!rst_ni)
    advance && !norm && !idle |=> res_q.not_stable && res_q.normal_step == 17'd0)
    else $error("inactive sample not flagged unstable");

  // Stored filter outputs stay within the clamp
  a_clamp: assert property (@(posedge clk_i) disable iff (!rst_ni)
    n_out_q <= TORQUE_LIMIT && n_out_q >= -TORQUE_LIMIT
    && i_out_q <= TORQUE_LIMIT && i_out_q >= -TORQUE_LIMIT)
    else $error("filter output outside clamp");

  // Input stalls only while a held sample waits behind a stalled result
  a_stall: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !in_ready_o |-> stg_valid_q && out_valid_q && !out_ready_i)
    else $error("input stalled without cause");

endmodule
